[sv/signed_q64_64_mul_div_unit_macros.svh]
// Assertion macros for the Q64.64 multiply/divide unit.
// Used by the top level; expects clk_i and rst_ni in scope.
`ifndef SIGNED_Q64_64_MUL_DIV_UNIT_MACROS_SVH
`define SIGNED_Q64_64_MUL_DIV_UNIT_MACROS_SVH

// same-cycle implication
`define QMD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define QMD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/qmd_pkg.sv]
// Shared types and constants for the Q64.64 multiply/divide unit.
// No dependencies.
package qmd_pkg;

  localparam int unsigned NCELL = 128;
  localparam int unsigned CNTW  = $clog2(NCELL);

  localparam logic [1:0] FN_MUL  = 2'd0;
  localparam logic [1:0] FN_DIV  = 2'd1;
  localparam logic [1:0] FN_MULR = 2'd2;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_OVF = 2'd1;
  localparam logic [1:0] ST_DZ  = 2'd2;

  typedef enum logic [1:0] {OP_IDLE, OP_MUL, OP_MULR, OP_DIV} op_e;

  typedef struct packed {
    logic [1:0]         func;
    logic signed [63:0] a_hi;
    logic [63:0]        a_lo;
    logic signed [63:0] b_hi;
    logic [63:0]        b_lo;
  } in_t;

  typedef struct packed {
    logic signed [63:0] res_hi;
    logic [63:0]        res_lo;
    logic [1:0]         status;
  } out_t;

  // one beat moving along the cell row
  typedef struct packed {
    logic            vld;
    op_e             op;
    logic [1:0]      func;
    logic            neg;
    logic            dz;
    logic            qovf;
    logic [63:0]     qlo;
    logic [255:0]    w;    // mul: accumulator; div: {remainder, dividend bits}
    logic [127:0]    x;    // mul: multiplicand; div: divisor
    logic [127:0]    y;    // mul: multiplier bits; div: quotient bits
    logic [CNTW-1:0] cnt;
  } beat_t;

  function automatic logic [127:0] mag128(logic [127:0] v);
    return v[127] ? (~v + 128'd1) : v;
  endfunction

endpackage

[sv/qmd_cell.sv]
// One cell of the row: a shift-add multiply step or a restoring divide step.
// Depends on qmd_pkg.
module qmd_cell import qmd_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  beat_t beat_i,
  output beat_t beat_o
);

  logic [127:0] xm, addend, rem, diff;
  logic         take;
  beat_t        nxt, pl_q;
  logic         vld_q;

  // reciprocal mode drops a_lo while walking the low half of b
  assign xm     = (beat_i.op == OP_MULR && beat_i.cnt[CNTW-1]) ?
                  {beat_i.x[127:64], 64'd0} : beat_i.x;
  assign addend = beat_i.y[127] ? xm : '0;
  assign rem    = beat_i.w[254:127];
  assign diff   = rem - beat_i.x;
  assign take   = beat_i.w[255] | (rem >= beat_i.x);

  always_comb begin
    nxt     = beat_i;
    nxt.cnt = beat_i.cnt + {{(CNTW-1){1'b0}}, 1'b1};
    unique case (beat_i.op)
      OP_MUL, OP_MULR: begin
        nxt.w = {beat_i.w[254:0], 1'b0} + {128'd0, addend};
        nxt.y = {beat_i.y[126:0], 1'b0};
      end
      OP_DIV: begin
        nxt.w = {(take ? diff : rem), beat_i.w[126:0], 1'b0};
        nxt.y = {beat_i.y[126:0], take};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= beat_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    pl_q <= nxt;
  end

  always_comb begin
    beat_o     = pl_q;
    beat_o.vld = vld_q;
  end

endmodule

[sv/qmd_chain.sv]
// Row of NCELL cells, one step each, a beat advancing one cell per cycle.
// Depends on qmd_pkg and qmd_cell.
module qmd_chain import qmd_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  beat_t beat_i,
  output beat_t beat_o
);

  beat_t link [0:NCELL];

  assign link[0] = beat_i;

  for (genvar k = 0; k < NCELL; k++) begin : g_cell
    qmd_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .beat_i (link[k]),
      .beat_o (link[k+1])
    );
  end

  assign beat_o = link[NCELL];

endmodule

[sv/signed_q64_64_mul_div_unit.sv]
// Signed Q64.64 multiply / divide / multiply-by-reciprocal unit, top level.
// Depends on qmd_pkg, qmd_chain and the assertion macro header.
//
// Usage:
//   Drive op_i and raise start; a beat is taken at each edge where start is
//   high and busy is low. busy never rises, so one operation can be issued
//   every cycle, back to back.
//   Each result shows on res_o with res_valid_o high for one cycle, in
//   issue order. The receiver cannot stall the unit; a result not
//   captured in that cycle is gone. The unit holds two rows of 128 cells:
//   the first does one multiply bit or one bit of the integer quotient per
//   cycle, the second one bit of the fractional quotient. Multiply beats
//   ride through the second row.
//   Around the rows sit an input register, an operand magnitude stage, a
//   remainder setup stage, a result select stage and the sign/output stage.
//   Throughput: one operation per cycle for every func.
//   status: ok, overflow (wrapped result), or divide by zero (result 0).
//   Reset (rst_ni low, asynchronous) drops every beat in flight; there is
//   no clearing pass, the unit takes work on the first cycle after reset.
`include "signed_q64_64_mul_div_unit_macros.svh"

module signed_q64_64_mul_div_unit import qmd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  in_t  op_i,
  output logic res_valid_o,
  output out_t res_o
);

  in_t          in_q;
  logic         in_vld_q;
  logic [127:0] a_mag, b_raw, b_mag;
  logic         na, nb;
  beat_t        ent, ent_q, ca, mid, mid_q, cb;
  logic         ent_vld_q, mid_vld_q;
  logic [128:0] qsum;
  logic [127:0] f_mag, f1_mag_q, fin;
  logic         f_ovf, f1_ovf_q, f1_neg_q, f1_dz_q, f1_vld_q, ovf2;
  out_t         res_q;
  logic         res_vld_q;

  assign busy = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      ent_vld_q <= 1'b0;
      mid_vld_q <= 1'b0;
      f1_vld_q  <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= start & ~busy;
      ent_vld_q <= in_vld_q;
      mid_vld_q <= ca.vld;
      f1_vld_q  <= cb.vld;
      res_vld_q <= f1_vld_q;
    end
  end

  // operand magnitudes
  assign a_mag = mag128({in_q.a_hi, in_q.a_lo});
  assign b_raw = {in_q.b_hi, in_q.b_lo};
  assign b_mag = mag128(b_raw);
  assign na    = in_q.a_hi[63];
  assign nb    = in_q.b_hi[63];

  always_comb begin
    ent      = '0;
    ent.vld  = in_vld_q;
    ent.func = in_q.func;
    unique case (in_q.func)
      FN_MUL: begin
        ent.op  = OP_MUL;
        ent.x   = a_mag;
        ent.y   = b_mag;
        ent.neg = na ^ nb;
      end
      FN_MULR: begin
        ent.op  = OP_MULR;
        ent.x   = a_mag;
        ent.y   = b_raw;
        ent.neg = na;
      end
      FN_DIV: begin
        ent.dz  = (b_raw == '0);
        ent.op  = (b_raw == '0) ? OP_IDLE : OP_DIV;
        ent.w   = {128'd0, a_mag};
        ent.x   = b_mag;
        ent.neg = na ^ nb;
      end
      default: ent.op = OP_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    in_q  <= op_i;
    ent_q <= ent;
    mid_q <= mid;
  end

  beat_t ent_b, mid_b;
  always_comb begin
    ent_b     = ent_q;
    ent_b.vld = ent_vld_q;
    mid_b     = mid_q;
    mid_b.vld = mid_vld_q;
  end

  qmd_chain u_row_a (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .beat_i (ent_b),
    .beat_o (ca)
  );

  // integer quotient is done: set up the fraction pass from the remainder
  always_comb begin
    mid = ca;
    if (ca.op == OP_DIV) begin
      mid.qovf = |ca.y[127:64];
      mid.qlo  = ca.y[63:0];
      mid.y    = '0;
      if (ca.w[255:192] == '0) begin
        mid.w = {128'd0, ca.w[191:128], 64'd0};
        mid.x = ca.x;
      end else begin
        mid.w = {128'd0, ca.w[255:128]};
        mid.x = {64'd0, ca.x[127:64]};
      end
    end else begin
      mid.op = OP_IDLE;
    end
  end

  qmd_chain u_row_b (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .beat_i (mid_b),
    .beat_o (cb)
  );

  assign qsum = {1'b0, cb.qlo, 64'd0} + {1'b0, cb.y};

  always_comb begin
    unique case (cb.func)
      FN_MUL: begin
        f_mag = cb.w[191:64];
        f_ovf = |cb.w[255:192];
      end
      FN_MULR: begin
        f_mag = cb.w[255:128];
        f_ovf = 1'b0;
      end
      FN_DIV: begin
        f_mag = cb.dz ? '0 : qsum[127:0];
        f_ovf = ~cb.dz & (cb.qovf | qsum[128]);
      end
      default: begin
        f_mag = '0;
        f_ovf = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    f1_mag_q <= f_mag;
    f1_ovf_q <= f_ovf;
    f1_neg_q <= cb.neg;
    f1_dz_q  <= cb.dz;
  end

  // apply sign; a negative result may reach exactly -2^63, raw value -2^127
  assign ovf2 = f1_neg_q ? (f1_ovf_q | (f1_mag_q > {1'b1, 127'd0}))
                         : (f1_ovf_q | f1_mag_q[127]);
  assign fin  = f1_neg_q ? (~f1_mag_q + 128'd1) : f1_mag_q;

  always_ff @(posedge clk_i) begin
    res_q.res_hi <= fin[127:64];
    res_q.res_lo <= fin[63:0];
    if (f1_dz_q) begin
      res_q.status <= ST_DZ;
    end else if (ovf2) begin
      res_q.status <= ST_OVF;
    end else begin
      res_q.status <= ST_OK;
    end
  end

  assign res_valid_o = res_vld_q;
  assign res_o       = res_q;

  `QMD_ASSERT_NEXT(a_row_to_mid, ca.vld, mid_vld_q, "row A beat lost before setup")
  `QMD_ASSERT_NEXT(a_sel_to_out, f1_vld_q, res_valid_o, "result beat lost at output")
  `QMD_ASSERT_NOW(a_dz_zero, res_valid_o && res_o.status == ST_DZ, res_o.res_hi == '0 && res_o.res_lo == '0, "divide by zero with nonzero result")

endmodule

[test/signed_q64_64_mul_div_unit_tb.sv]
// Self-checking testbench for the signed Q64.64 multiply/divide unit.
// Depends on qmd_pkg and the signed_q64_64_mul_div_unit top level.
module signed_q64_64_mul_div_unit_tb;
  import qmd_pkg::*;

  localparam int LATENCY  = 260;
  localparam int N_RANDOM = 1330;
  localparam logic [63:0] MSB64 = 64'h8000_0000_0000_0000;
  localparam logic [1:0] FN_UNUSED = 2'd3;

  logic clk_i, rst_ni, start, busy, res_valid_o;
  in_t  op_i;
  out_t res_o;

  signed_q64_64_mul_div_unit i_dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .op_i(op_i), .res_valid_o(res_valid_o), .res_o(res_o)
  );

  out_t pending_q[$];
  int   n_err, n_res, n_ovf, n_dz;
  int   n_fn[4];

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #60_000_000;
    $display("signed_q64_64_mul_div_unit_tb: done, errors");
    $finish;
  end

  // unsigned restoring divide, 128 by 128; den nonzero
  function automatic void udiv128(input logic [127:0] num, den,
                                  output logic [127:0] quo, rem);
    logic [128:0] r;
    r   = '0;
    quo = '0;
    for (int i = 127; i >= 0; i--) begin
      r = {r[127:0], num[i]};
      if (r >= {1'b0, den}) begin
        r      = r - {1'b0, den};
        quo[i] = 1'b1;
      end
    end
    rem = r[127:0];
  endfunction

  function automatic logic [127:0] abs128(logic [127:0] v);
    return v[127] ? -v : v;
  endfunction

  // apply the sign, flag values outside the signed range
  function automatic out_t signed_out(logic neg, logic [127:0] m, logic ovf);
    out_t o;
    if (neg) begin
      if (m > {MSB64, 64'd0}) ovf = 1'b1;
      m = -m;
    end else if (m[127]) ovf = 1'b1;
    o.res_hi = m[127:64];
    o.res_lo = m[63:0];
    o.status = ovf ? ST_OVF : ST_OK;
    return o;
  endfunction

  function automatic out_t predict_q64(in_t x);
    logic [127:0] av, bv, ma, mb, q, r, q2, r2, num, den;
    logic [255:0] prod;
    logic [128:0] sum;
    out_t o;
    av = {x.a_hi, x.a_lo};
    bv = {x.b_hi, x.b_lo};
    ma = abs128(av);
    mb = abs128(bv);
    o  = '0;
    o.status = ST_OK;
    case (x.func)
      FN_MUL: begin
        prod = {128'd0, ma} * {128'd0, mb};
        o = signed_out(av[127] ^ bv[127], prod[191:64], prod[255:192] != 0);
      end
      FN_DIV: begin
        if (bv == 0) begin
          o.status = ST_DZ;
        end else begin
          udiv128(ma, mb, q, r);
          if (r[127:64] == 0) begin
            num = {r[63:0], 64'd0};
            den = mb;
          end else begin
            num = r;
            den = {64'd0, mb[127:64]};
          end
          udiv128(num, den, q2, r2);
          sum = {1'b0, q[63:0], 64'd0} + {1'b0, q2};
          o = signed_out(av[127] ^ bv[127], sum[127:0],
                         q[127:64] != 0 || sum[128]);
        end
      end
      FN_MULR: begin
        // |a|*b without the low-by-low term, top 128 bits kept
        prod = {128'd0, ma} * {128'd0, bv}
             - {192'd0, ma[63:0]} * {192'd0, bv[63:0]};
        o = signed_out(av[127], prod[255:128], 1'b0);
      end
      default: ;
    endcase
    return o;
  endfunction

  // result side: compare each beat with the oldest expectation
  always @(posedge clk_i) begin
    out_t e;
    if (rst_ni && res_valid_o) begin
      n_res++;
      if (pending_q.size() == 0) begin
        $error("result beat with nothing pending");
        n_err++;
      end else begin
        e = pending_q.pop_front();
        if (res_o.res_hi !== e.res_hi) begin
          $error("res_hi: expected %h, got %h", e.res_hi, res_o.res_hi);
          n_err++;
        end
        if (res_o.res_lo !== e.res_lo) begin
          $error("res_lo: expected %h, got %h", e.res_lo, res_o.res_lo);
          n_err++;
        end
        if (res_o.status !== e.status) begin
          $error("status: expected %0d, got %0d", e.status, res_o.status);
          n_err++;
        end
      end
    end
  end

  // issue one beat; the expectation is queued at the accepting edge
  task automatic issue(in_t x, out_t exp_o, bit typed);
    @(negedge clk_i);
    start = 1'b1;
    op_i  = x;
    do @(posedge clk_i); while (busy);
    pending_q.push_back(typed ? exp_o : predict_q64(x));
    n_fn[x.func]++;
    if (exp_o.status == ST_OVF || predict_q64(x).status == ST_OVF) n_ovf++;
    if (predict_q64(x).status == ST_DZ) n_dz++;
  endtask

  task automatic idle_gap(int n);
    @(negedge clk_i);
    start = 1'b0;
    repeat (n > 0 ? n - 1 : 0) @(negedge clk_i);
  endtask

  function automatic logic [63:0] rnd64();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 7))
      0: v = 64'd0;
      1: v = 64'hFFFF_FFFF_FFFF_FFFF;
      2: v = MSB64;
      3: v = {1'b0, {63{1'b1}}};
      4: v = 64'(v >> $urandom_range(1, 63));
      5: v = -64'(v >> $urandom_range(1, 63));
      default: ;
    endcase
    return v;
  endfunction

  typedef struct {
    in_t  stim;
    out_t exp_o;
    bit   typed;
  } row_t;

  initial begin
    row_t  rows[$];
    in_t   x;
    out_t  z;
    int    burst;
    n_err = 0; n_res = 0; n_ovf = 0; n_dz = 0;
    n_fn  = '{default: 0};
    rst_ni = 1'b0;
    start  = 1'b0;
    op_i   = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    z = '0;
    // directed table: typed rows where the answer is plain, predict_q64 rows for the rest
    rows = '{
      '{'{FN_MUL, 64'd0, 64'd0, 64'd0, 64'd0}, '{64'd0, 64'd0, ST_OK}, 1},
      '{'{FN_MUL, 64'd1, 64'd0, 64'd1, 64'd0}, '{64'd1, 64'd0, ST_OK}, 1},
      '{'{FN_MUL, -64'sd1, 64'd0, 64'd3, 64'd0}, '{-64'sd3, 64'd0, ST_OK}, 1},
      '{'{FN_MUL, 64'd0, 64'h8000_0000_0000_0000, 64'd0, 64'h8000_0000_0000_0000},
        '{64'd0, 64'h4000_0000_0000_0000, ST_OK}, 1},
      '{'{FN_MUL, MSB64, 64'd0, MSB64, 64'd0}, z, 0},
      '{'{FN_MUL, MSB64, 64'd0, -64'sd1, 64'd0}, z, 0},
      '{'{FN_MUL, 64'h7FFF_FFFF_FFFF_FFFF, '1, 64'h7FFF_FFFF_FFFF_FFFF, '1}, z, 0},
      '{'{FN_MUL, '1, '1, '1, '1}, z, 0},
      '{'{FN_DIV, 64'd5, 64'd0, 64'd0, 64'd0}, '{64'd0, 64'd0, ST_DZ}, 1},
      '{'{FN_DIV, MSB64, 64'd0, 64'd0, 64'd0}, '{64'd0, 64'd0, ST_DZ}, 1},
      '{'{FN_DIV, 64'd6, 64'd0, 64'd3, 64'd0}, '{64'd2, 64'd0, ST_OK}, 1},
      '{'{FN_DIV, 64'd1, 64'd0, 64'd2, 64'd0},
        '{64'd0, 64'h8000_0000_0000_0000, ST_OK}, 1},
      '{'{FN_DIV, MSB64, 64'd0, -64'sd1, 64'd0}, z, 0},
      '{'{FN_DIV, MSB64, 64'd0, 64'd0, 64'd1}, z, 0},
      '{'{FN_DIV, 64'd7, 64'd5, 64'h0000_0001_0000_0000, 64'd3}, z, 0},
      '{'{FN_DIV, -64'sd9, 64'd1, 64'd2, 64'd7}, z, 0},
      // reciprocal is a 128-bit fraction: top bit set means one half
      '{'{FN_MULR, 64'd1, 64'd0, MSB64, 64'd0},
        '{64'd0, 64'h8000_0000_0000_0000, ST_OK}, 1},
      '{'{FN_MULR, MSB64, 64'd0, '1, '1}, z, 0},
      '{'{FN_MULR, 64'h7FFF_FFFF_FFFF_FFFF, '1, '1, '1}, z, 0},
      '{'{FN_MULR, -64'sd1, '1, '1, '1}, z, 0},
      '{'{FN_UNUSED, '1, '1, '1, '1}, '{64'd0, 64'd0, ST_OK}, 1},
      '{'{FN_UNUSED, MSB64, 64'd0, 64'd0, 64'd0}, '{64'd0, 64'd0, ST_OK}, 1}
    };
    foreach (rows[i]) issue(rows[i].stim, rows[i].exp_o, rows[i].typed);

    // random bursts with random gaps, long back-to-back runs included
    for (int k = 0; k < N_RANDOM; ) begin
      burst = $urandom_range(1, 40);
      for (int j = 0; j < burst && k < N_RANDOM; j++, k++) begin
        x.func = ($urandom_range(0, 30) == 0) ? FN_UNUSED
               : 2'($urandom_range(0, 2));
        x.a_hi = rnd64(); x.a_lo = rnd64();
        x.b_hi = rnd64(); x.b_lo = rnd64();
        if (x.func == FN_DIV && $urandom_range(0, 3) == 0) begin
          // keep quotients in range more often so fractions get exercised
          x.a_hi = 64'($signed(x.a_hi) >>> $urandom_range(0, 63));
        end
        issue(x, z, 0);
      end
      if ($urandom_range(0, 3) != 0) idle_gap($urandom_range(1, 12));
    end
    @(negedge clk_i);
    start = 1'b0;

    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);

    $display("covered: %0d results (mul %0d, div %0d, mulr %0d, unused %0d)",
             n_res, n_fn[0], n_fn[1], n_fn[2], n_fn[3]);
    $display("covered: %0d overflow and %0d divide-by-zero cases", n_ovf, n_dz);
    if (n_err == 0 && pending_q.size() == 0) begin
      $display("signed_q64_64_mul_div_unit_tb: done, clean");
    end else begin
      $display("signed_q64_64_mul_div_unit_tb: done, errors");
    end
    $finish;
  end
endmodule
